// ===== hdl/mds_pkg.sv =====
// ============================================================================
// Maze DFS solver package
// Grid geometry, cell codes, opcodes and the command and status bundles that
// join the solver's controller and datapath.
// ============================================================================
package mds_pkg;

  // Grid geometry.
  localparam int ROWS    = 32;
  localparam int COLS    = 32;
  localparam int CELLS   = ROWS * COLS;
  localparam int CROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CCOL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int DEPTH_W = $clog2(CELLS + 1);
  localparam int STK_W   = CROW_W + CCOL_W;

  // Transaction field widths.
  localparam int OP_W   = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int CELL_W = 8;

  // Cell codes.
  localparam logic [CELL_W-1:0] CELL_OPEN    = 8'd32;
  localparam logic [CELL_W-1:0] CELL_VISITED = 8'd46;
  localparam logic [CELL_W-1:0] CELL_DEAD    = 8'd126;

  // Opcodes. The reserved code is taken and dropped without a result.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // Result kinds.
  localparam logic KIND_SOLVE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Neighbor search order.
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef enum logic [1:0] {
    ADDR_IN,
    ADDR_CUR,
    ADDR_NBR
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_IN,
    WD_VISITED,
    WD_DEAD
  } wdata_sel_e;

  typedef struct packed {
    logic       req_ld;
    logic       grid_we;
    logic       grid_re;
    addr_sel_e  addr_sel;
    wdata_sel_e wd_sel;
    logic       depth_init;
    logic       push;
    logic       pop;
    logic       cur_from_stk;
    logic       dir_clr;
    logic       dir_inc;
    logic       out_ld;
    logic       out_kind;
    logic       out_found;
  } mds_cmd_t;

  typedef struct packed {
    logic in_in_grid;
    logic start_in;
    logic start_is_goal;
    logic nbr_ok;
    logic nbr_open;
    logic nbr_is_goal;
    logic dir_last;
    logic depth_one;
    logic out_free;
  } mds_sts_t;

  function automatic logic [IDX_W-1:0] cell_idx(input logic [CROW_W-1:0] r,
                                                input logic [CCOL_W-1:0] c);
    return IDX_W'(int'(r) * COLS + int'(c));
  endfunction

endpackage

// ===== hdl/mds_dpath.sv =====
// ============================================================================
// Maze DFS solver datapath
// Grid memory, path stack memory, current cell and neighbor logic, depth
// counter and the output register.
// ============================================================================
module mds_dpath import mds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mds_cmd_t          cmd_i,
  output mds_sts_t          sts_o,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [CELL_W-1:0] cell_value_i,
  input  logic [ROW_W-1:0]  goal_row_i,
  input  logic [COL_W-1:0]  goal_col_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              result_kind_o,
  output logic              found_o,
  output logic [CELL_W-1:0] cell_mark_o
);

  logic [CELL_W-1:0]  grid_mem [CELLS];
  logic [STK_W-1:0]   stk_mem  [CELLS];
  logic [CELL_W-1:0]  grid_rdata_q;
  logic [STK_W-1:0]   stk_rdata_q;

  logic [CROW_W-1:0]  cur_r_q, cur_r_d;
  logic [CCOL_W-1:0]  cur_c_q, cur_c_d;
  logic [CROW_W-1:0]  goal_r_q, goal_r_d;
  logic [CCOL_W-1:0]  goal_c_q, goal_c_d;
  logic               goal_in_q, goal_in_d;
  logic               start_in_q, start_in_d;
  logic [1:0]         dir_q, dir_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [DEPTH_W-1:0] depth_m1, depth_m2;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic               found_q, found_d;
  logic [CELL_W-1:0]  mark_q, mark_d;

  logic [CROW_W-1:0]  nbr_r;
  logic [CCOL_W-1:0]  nbr_c;
  logic               nbr_ok;
  logic [IDX_W-1:0]   grid_addr;
  logic [CELL_W-1:0]  grid_wdata;
  logic               in_in_grid;
  logic               goal_req_in;
  logic               out_free;

  assign in_in_grid  = (int'(row_i) < ROWS) && (int'(col_i) < COLS);
  assign goal_req_in = (int'(goal_row_i) < ROWS) && (int'(goal_col_i) < COLS);
  assign depth_m1    = depth_q - DEPTH_W'(1);
  assign depth_m2    = depth_q - DEPTH_W'(2);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Neighbor of the current cell in the direction under test.
  always_comb begin
    nbr_r  = cur_r_q;
    nbr_c  = cur_c_q;
    nbr_ok = 1'b0;
    case (dir_q)
      DIR_DOWN: begin
        nbr_ok = (int'(cur_r_q) + 1) < ROWS;
        nbr_r  = cur_r_q + CROW_W'(1);
      end
      DIR_RIGHT: begin
        nbr_ok = (int'(cur_c_q) + 1) < COLS;
        nbr_c  = cur_c_q + CCOL_W'(1);
      end
      DIR_LEFT: begin
        nbr_ok = (cur_c_q != '0);
        nbr_c  = cur_c_q - CCOL_W'(1);
      end
      DIR_UP: begin
        nbr_ok = (cur_r_q != '0);
        nbr_r  = cur_r_q - CROW_W'(1);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_IN:  grid_addr = cell_idx(CROW_W'(row_i), CCOL_W'(col_i));
      ADDR_CUR: grid_addr = cell_idx(cur_r_q, cur_c_q);
      ADDR_NBR: grid_addr = cell_idx(nbr_r, nbr_c);
      default:  grid_addr = cell_idx(cur_r_q, cur_c_q);
    endcase
    case (cmd_i.wd_sel)
      WD_IN:      grid_wdata = cell_value_i;
      WD_VISITED: grid_wdata = CELL_VISITED;
      WD_DEAD:    grid_wdata = CELL_DEAD;
      default:    grid_wdata = CELL_DEAD;
    endcase
  end

  // Grid memory: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.grid_we) begin
      grid_mem[grid_addr] <= grid_wdata;
    end
    if (cmd_i.grid_re) begin
      grid_rdata_q <= grid_mem[grid_addr];
    end
  end

  // Path stack memory holds every path entry below the current cell.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_mem[depth_m1[IDX_W-1:0]] <= {cur_r_q, cur_c_q};
    end
    if (cmd_i.pop) begin
      stk_rdata_q <= stk_mem[depth_m2[IDX_W-1:0]];
    end
  end

  always_comb begin
    cur_r_d    = cur_r_q;
    cur_c_d    = cur_c_q;
    goal_r_d   = goal_r_q;
    goal_c_d   = goal_c_q;
    goal_in_d  = goal_in_q;
    start_in_d = start_in_q;
    if (cmd_i.req_ld) begin
      cur_r_d    = CROW_W'(row_i);
      cur_c_d    = CCOL_W'(col_i);
      goal_r_d   = CROW_W'(goal_row_i);
      goal_c_d   = CCOL_W'(goal_col_i);
      goal_in_d  = goal_req_in;
      start_in_d = in_in_grid;
    end else if (cmd_i.push) begin
      cur_r_d = nbr_r;
      cur_c_d = nbr_c;
    end else if (cmd_i.cur_from_stk) begin
      cur_r_d = stk_rdata_q[STK_W-1:CCOL_W];
      cur_c_d = stk_rdata_q[CCOL_W-1:0];
    end
  end

  always_comb begin
    dir_d = dir_q;
    if (cmd_i.dir_clr) begin
      dir_d = DIR_DOWN;
    end else if (cmd_i.dir_inc) begin
      dir_d = dir_q + 2'd1;
    end
    depth_d = depth_q;
    if (cmd_i.depth_init) begin
      depth_d = DEPTH_W'(1);
    end else if (cmd_i.push) begin
      depth_d = depth_q + DEPTH_W'(1);
    end else if (cmd_i.pop) begin
      depth_d = depth_m1;
    end
  end

  always_comb begin
    out_valid_d = cmd_i.out_ld || (out_valid_q && out_stall_i);
    kind_d      = kind_q;
    found_d     = found_q;
    mark_d      = mark_q;
    if (cmd_i.out_ld) begin
      kind_d  = cmd_i.out_kind;
      found_d = cmd_i.out_found;
      mark_d  = (cmd_i.out_kind == KIND_READ && start_in_q) ? grid_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DIR_DOWN;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dir_q       <= dir_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q    <= cur_r_d;
    cur_c_q    <= cur_c_d;
    goal_r_q   <= goal_r_d;
    goal_c_q   <= goal_c_d;
    goal_in_q  <= goal_in_d;
    start_in_q <= start_in_d;
    kind_q     <= kind_d;
    found_q    <= found_d;
    mark_q     <= mark_d;
  end

  always_comb begin
    sts_o.in_in_grid    = in_in_grid;
    sts_o.start_in      = start_in_q;
    sts_o.start_is_goal = goal_in_q && cur_r_q == goal_r_q && cur_c_q == goal_c_q;
    sts_o.nbr_ok        = nbr_ok;
    sts_o.nbr_open      = (grid_rdata_q == CELL_OPEN);
    sts_o.nbr_is_goal   = goal_in_q && nbr_r == goal_r_q && nbr_c == goal_c_q;
    sts_o.dir_last      = (dir_q == DIR_UP);
    sts_o.depth_one     = (depth_q == DEPTH_W'(1));
    sts_o.out_free      = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign found_o       = found_q;
  assign cell_mark_o   = mark_q;

`ifndef SYNTHESIS
  // A path can never hold more cells than the grid has.
  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (depth_q < DEPTH_W'(CELLS)))
    else $error("path stack push beyond grid size");

  // Backtracking only happens while a path exists.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (depth_q != '0))
    else $error("path stack pop while empty");

  // A result is never written over one that is still waiting.
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== hdl/mds_ctrl.sv =====
// ============================================================================
// Maze DFS solver controller
// Sequences load, read and solve transactions and drives the datapath.
// ============================================================================
module mds_ctrl import mds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [OP_W-1:0] opcode_i,
  input  mds_sts_t        sts_i,
  output mds_cmd_t        cmd_o
);

  localparam int         STATE_W = 3;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DEAD  = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [STATE_W-1:0] state_q, state_d;
  logic               found_q, found_d;
  logic               in_acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_IN;
    cmd_o.wd_sel   = WD_IN;
    state_d        = state_q;
    found_d        = found_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.req_ld = 1'b1;
          case (opcode_i)
            OP_LOAD: begin
              cmd_o.grid_we = sts_i.in_in_grid;
            end
            OP_READ: begin
              cmd_o.grid_re = 1'b1;
              state_d       = S_READ;
            end
            OP_SOLVE: begin
              state_d = S_START;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = KIND_READ;
          state_d        = S_IDLE;
        end
      end
      S_START: begin
        if (!sts_i.start_in) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.grid_we    = 1'b1;
          cmd_o.addr_sel   = ADDR_CUR;
          cmd_o.wd_sel     = WD_VISITED;
          cmd_o.depth_init = 1'b1;
          cmd_o.dir_clr    = 1'b1;
          if (sts_i.start_is_goal) begin
            found_d = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (sts_i.nbr_ok) begin
          cmd_o.grid_re  = 1'b1;
          cmd_o.addr_sel = ADDR_NBR;
          state_d        = S_CHECK;
        end else if (sts_i.dir_last) begin
          state_d = S_DEAD;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts_i.nbr_open) begin
          cmd_o.grid_we  = 1'b1;
          cmd_o.addr_sel = ADDR_NBR;
          cmd_o.wd_sel   = WD_VISITED;
          if (sts_i.nbr_is_goal) begin
            found_d = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.push    = 1'b1;
            cmd_o.dir_clr = 1'b1;
            state_d       = S_PROBE;
          end
        end else if (sts_i.dir_last) begin
          state_d = S_DEAD;
        end else begin
          cmd_o.dir_inc = 1'b1;
          state_d       = S_PROBE;
        end
      end
      S_DEAD: begin
        cmd_o.grid_we  = 1'b1;
        cmd_o.addr_sel = ADDR_CUR;
        cmd_o.wd_sel   = WD_DEAD;
        cmd_o.pop      = 1'b1;
        if (sts_i.depth_one) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd_o.cur_from_stk = 1'b1;
        cmd_o.dir_clr      = 1'b1;
        state_d            = S_PROBE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld    = 1'b1;
          cmd_o.out_kind  = KIND_SOLVE;
          cmd_o.out_found = found_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

`ifndef SYNTHESIS
  // The controller leaves idle only for an accepted transaction.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_acc) |=> (state_q == S_IDLE))
    else $error("left idle without a transaction");

  // Results come only from the read and solve-finish states.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (state_q == S_READ || state_q == S_DONE))
    else $error("result written from an unexpected state");

  // A finished solve waits while the output register is blocked.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !sts_i.out_free) |=> (state_q == S_DONE && $stable(found_q)))
    else $error("solve answer lost while output blocked");
`endif

endmodule

// ===== hdl/maze_dfs_solver_top.sv =====
// ============================================================================
// Maze DFS solver top level
// Grid maze solver by depth-first search with backtracking over a byte grid.
// ============================================================================
// A load transaction writes one grid byte (32 is an open passage, anything
// else blocks); loads can be issued back to back. A read transaction
// returns the byte of one cell, and a solve transaction marks the start
// cell 46, walks the grid trying down, right, left and up, marks dead ends
// 126 and answers whether the goal was reached. The single grid memory
// port has registered read data, so every neighbor probe is a read followed
// by a check. The input side is stalled while a read or a solve is in
// progress. Each result sits in an output register, so the block takes the
// next transaction while an earlier result is still waiting to be taken.
// Out-of-grid loads are dropped, out-of-grid reads return 0, and an
// out-of-grid start answers not found without touching the grid.

module maze_dfs_solver_top import mds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [CELL_W-1:0] cell_value_i,
  input  logic [ROW_W-1:0]  goal_row_i,
  input  logic [COL_W-1:0]  goal_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic              found_o,
  output logic [CELL_W-1:0] cell_mark_o
);

  mds_cmd_t cmd;
  mds_sts_t sts;

  // The controller sequences the search; it sees only status from the
  // datapath and the valid and opcode of the incoming transaction.
  mds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the grid, the path stack and the output register.
  mds_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .row_i         (row_i),
    .col_i         (col_i),
    .cell_value_i  (cell_value_i),
    .goal_row_i    (goal_row_i),
    .goal_col_i    (goal_col_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .found_o       (found_o),
    .cell_mark_o   (cell_mark_o)
  );

endmodule

// ===== tb/tb_maze_dfs_solver_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Maze DFS solver testbench
// Fills the whole grid, runs a short table of directed transactions, then
// random mazes in regions of the grid with solves and read-backs, and noise.
// Results are checked against a typed table value or a depth-first search
// predictor that keeps its own copy of the grid.
// ============================================================================

module tb_maze_dfs_solver_top import mds_pkg::*; ();

  // Marks a table row whose expected result is left to the predictor.
  localparam int UNTYPED        = -1;
  localparam int RANDOM_ITEMS   = 500;
  localparam int HOLD_CYCLES    = 250;
  // The watchdog limit: a quiet stretch this long is taken to mean the
  // block has hung.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] val;
    logic [ROW_W-1:0]  grow;
    logic [COL_W-1:0]  gcol;
  } maze_item_t;

  typedef struct {
    logic              kind;
    logic              found;
    logic [CELL_W-1:0] mark;
  } maze_result_t;

  // A result typed into the directed table travels with its transaction.
  typedef struct {
    bit           given;
    maze_result_t want;
  } answer_hint_t;

  typedef struct {
    maze_item_t item;
    int         typed;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [ROW_W-1:0]  row_i;
  logic [COL_W-1:0]  col_i;
  logic [CELL_W-1:0] cell_value_i;
  logic [ROW_W-1:0]  goal_row_i;
  logic [COL_W-1:0]  goal_col_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              result_kind_o;
  logic              found_o;
  logic [CELL_W-1:0] cell_mark_o;

  // Predictor state: the grid as the block should hold it.
  logic [CELL_W-1:0] maze_grid [CELLS];

  maze_result_t  awaited_answers [$];
  answer_hint_t  typed_hints [$];
  directed_row_t directed_rows [$];

  int mismatch_count;
  int items_sent;
  int quiet_cycles;
  bit steady_traffic;
  bit hold_request;
  bit hold_taken;

  maze_dfs_solver_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cell_value_i (cell_value_i),
    .goal_row_i   (goal_row_i),
    .goal_col_i   (goal_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .found_o      (found_o),
    .cell_mark_o  (cell_mark_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Depth-first walk from the start cell. Open neighbors are taken in the
  // order down, right, left, up; a cell with none left is marked dead and the
  // walk backs up one step. Returns whether the goal was stepped onto.
  function automatic bit walk_maze(input int sr, input int sc, input int gr,
                                   input int gc);
    int trail [$];
    int start_ix;
    int goal_ix;
    int here;
    int step;
    int r;
    int c;
    bit reached;
    if (sr >= ROWS || sc >= COLS) return 1'b0;
    start_ix = sr * COLS + sc;
    goal_ix  = (gr < ROWS && gc < COLS) ? gr * COLS + gc : CELLS;
    // The start is marked visited even when it held a wall.
    maze_grid[start_ix] = CELL_VISITED;
    if (start_ix == goal_ix) return 1'b1;
    reached = 1'b0;
    trail.push_back(start_ix);
    while (trail.size() > 0 && !reached) begin
      here = trail[$];
      r    = here / COLS;
      c    = here % COLS;
      step = CELLS;
      if (r + 1 < ROWS && maze_grid[here + COLS] == CELL_OPEN) step = here + COLS;
      else if (c + 1 < COLS && maze_grid[here + 1] == CELL_OPEN) step = here + 1;
      else if (c > 0 && maze_grid[here - 1] == CELL_OPEN) step = here - 1;
      else if (r > 0 && maze_grid[here - COLS] == CELL_OPEN) step = here - COLS;
      if (step < CELLS) begin
        maze_grid[step] = CELL_VISITED;
        if (step == goal_ix) reached = 1'b1;
        else trail.push_back(step);
      end else begin
        maze_grid[here] = CELL_DEAD;
        void'(trail.pop_back());
      end
    end
    return reached;
  endfunction

  // Applies one accepted transaction to the grid copy. Returns 1 when the
  // transaction produces a result, which is then left in ans.
  function automatic bit predict_answer(input maze_item_t it, output maze_result_t ans);
    bit in_grid;
    int ix;
    in_grid   = (int'(it.row) < ROWS) && (int'(it.col) < COLS);
    ix        = int'(it.row) * COLS + int'(it.col);
    ans.kind  = KIND_SOLVE;
    ans.found = 1'b0;
    ans.mark  = '0;
    case (it.op)
      OP_LOAD: begin
        if (in_grid) maze_grid[ix] = it.val;
        return 1'b0;
      end
      OP_SOLVE: begin
        ans.found = walk_maze(int'(it.row), int'(it.col), int'(it.grow), int'(it.gcol));
        return 1'b1;
      end
      OP_READ: begin
        ans.kind = KIND_READ;
        if (in_grid) ans.mark = maze_grid[ix];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_answer(input maze_result_t got);
    maze_result_t want;
    if (awaited_answers.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind=%0b found=%0b mark=%0d",
                              got.kind, got.found, got.mark));
      return;
    end
    want = awaited_answers.pop_front();
    if (got.kind !== want.kind)
      note_mismatch($sformatf("result_kind %0b, expected %0b", got.kind, want.kind));
    if (got.found !== want.found)
      note_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
    if (got.mark !== want.mark)
      note_mismatch($sformatf("cell_mark %0d, expected %0d", got.mark, want.mark));
  endtask

  // Both channels are sampled at the clock edge, before the edge's own
  // updates land, so a transaction is seen exactly when the block takes it.
  // The output side is handled first: no result can leave in the same cycle
  // that its transaction arrives.
  always @(posedge clk_i) begin
    maze_item_t   seen;
    maze_result_t got;
    maze_result_t ans;
    answer_hint_t hint;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kind  = result_kind_o;
        got.found = found_o;
        got.mark  = cell_mark_o;
        check_answer(got);
      end
      if (in_valid_i && !in_stall_o) begin
        seen.op   = opcode_i;
        seen.row  = row_i;
        seen.col  = col_i;
        seen.val  = cell_value_i;
        seen.grow = goal_row_i;
        seen.gcol = goal_col_i;
        hint.given = 1'b0;
        if (typed_hints.size() > 0) hint = typed_hints.pop_front();
        if (predict_answer(seen, ans)) begin
          // The predictor still walks the grid for a typed row, so the grid
          // copy stays in step; only the expected values are replaced.
          if (hint.given) ans = hint.want;
          awaited_answers.push_back(ans);
        end
      end
    end
  end

  // Watchdog: the run is over when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, none while traffic is steady, and one
  // long hold-off on request so that the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !steady_traffic && ($urandom_range(99) < 22);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Transaction sender
  // --------------------------------------------------------------------------

  // Offers one transaction and returns at the edge that accepts it. Idle
  // cycles may come first, each one drawn on its own, with valid low.
  task automatic send_item(input maze_item_t it, input int typed);
    answer_hint_t hint;
    while (!steady_traffic && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= it.op;
    row_i        <= it.row;
    col_i        <= it.col;
    cell_value_i <= it.val;
    goal_row_i   <= it.grow;
    goal_col_i   <= it.gcol;
    hint.given      = (typed != UNTYPED);
    hint.want.kind  = (it.op == OP_READ) ? KIND_READ : KIND_SOLVE;
    hint.want.found = (it.op == OP_SOLVE) ? typed[0] : 1'b0;
    hint.want.mark  = (it.op == OP_READ) ? typed[CELL_W-1:0] : '0;
    typed_hints.push_back(hint);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int row, input int col,
                         input int val, input int grow, input int gcol);
    maze_item_t it;
    it.op   = op;
    it.row  = ROW_W'(row);
    it.col  = COL_W'(col);
    it.val  = CELL_W'(val);
    it.grow = ROW_W'(grow);
    it.gcol = COL_W'(gcol);
    send_item(it, UNTYPED);
  endtask

  task automatic table_row(input logic [OP_W-1:0] op, input int row, input int col,
                           input int val, input int grow, input int gcol,
                           input int typed);
    directed_row_t dr;
    dr.item.op   = op;
    dr.item.row  = ROW_W'(row);
    dr.item.col  = COL_W'(col);
    dr.item.val  = CELL_W'(val);
    dr.item.grow = ROW_W'(grow);
    dr.item.gcol = COL_W'(gcol);
    dr.typed     = typed;
    directed_rows.push_back(dr);
  endtask

  // Any byte except the open passage code.
  function automatic int wall_byte();
    int v;
    do v = $urandom_range(255); while (v == int'(CELL_OPEN));
    return v;
  endfunction

  // Parks the sender until every awaited result has come back.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  // Random part. Most episodes load a small rectangle with a random maze,
  // solve inside it and read cells back; the rest is scattered noise. The
  // rest of the grid keeps its earlier marks and walls, so later walks run
  // into what earlier ones left behind.
  task automatic random_mazes();
    int first;
    int episode;
    int r0;
    int c0;
    int h;
    int w;
    int open_pct;
    int sr;
    int sc;
    int gr;
    int gc;
    int pick;
    first   = items_sent;
    episode = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      steady_traffic = (items_sent - first >= 150) && (items_sent - first < 300);
      if (episode == 3) begin
        // Long receiver hold-off while reads keep coming.
        hold_request = 1'b1;
        repeat (12) send_op(OP_READ, $urandom_range(31), $urandom_range(31), 0, 0, 0);
      end else if (episode == 10) begin
        drain_answers();
      end
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(24) == 0) begin
          h = $urandom_range(20, 10);
          w = $urandom_range(20, 10);
        end else begin
          h = $urandom_range(7, 2);
          w = $urandom_range(7, 2);
        end
        r0       = $urandom_range(ROWS - h);
        c0       = $urandom_range(COLS - w);
        open_pct = $urandom_range(75, 40);
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) begin
            send_op(OP_LOAD, r0 + r, c0 + c,
                    ($urandom_range(99) < open_pct) ? int'(CELL_OPEN) : wall_byte(),
                    0, 0);
          end
        end
        sr = r0 + $urandom_range(h - 1);
        sc = c0 + $urandom_range(w - 1);
        if ($urandom_range(99) < 80) begin
          gr = r0 + $urandom_range(h - 1);
          gc = c0 + $urandom_range(w - 1);
        end else begin
          gr = $urandom_range(31);
          gc = $urandom_range(31);
        end
        if ($urandom_range(99) < 80) send_op(OP_LOAD, gr, gc, int'(CELL_OPEN), 0, 0);
        send_op(OP_SOLVE, sr, sc, 0, gr, gc);
        repeat ($urandom_range(4, 1))
          send_op(OP_READ, r0 + $urandom_range(h - 1), c0 + $urandom_range(w - 1),
                  0, 0, 0);
        // A second walk over the marks the first one left.
        if ($urandom_range(99) < 25)
          send_op(OP_SOLVE, r0 + $urandom_range(h - 1), c0 + $urandom_range(w - 1), 0,
                  gr, gc);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          pick = $urandom_range(9);
          if (pick < 4)
            send_op(OP_READ, $urandom_range(31), $urandom_range(31), 0, 0, 0);
          else if (pick < 7)
            send_op(OP_LOAD, $urandom_range(31), $urandom_range(31),
                    $urandom_range(255), 0, 0);
          else if (pick < 9)
            send_op(OP_RSVD, $urandom_range(31), $urandom_range(31),
                    $urandom_range(255), $urandom_range(31), $urandom_range(31));
          else
            send_op(OP_SOLVE, $urandom_range(31), $urandom_range(31), 0,
                    $urandom_range(31), $urandom_range(31));
        end
      end
      episode++;
    end
    steady_traffic = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_LOAD;
    row_i          = '0;
    col_i          = '0;
    cell_value_i   = '0;
    goal_row_i     = '0;
    goal_col_i     = '0;
    mismatch_count = 0;
    items_sent     = 0;
    steady_traffic = 1'b0;
    hold_request   = 1'b0;
    for (int i = 0; i < CELLS; i++) maze_grid[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every cell is written before anything reads or walks over it; the
    // grid starts as solid wall of assorted bytes.
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++) send_op(OP_LOAD, r, c, wall_byte(), 0, 0);

    // Directed table: byte extremes, start on goal, a walled-in start, a
    // corner maze with one dead end, the far corner with the goal out of
    // reach, and the unused opcode with every field at its top value.
    table_row(OP_LOAD,  0,  0, 255,  0,  0, UNTYPED);
    table_row(OP_READ,  0,  0,   0,  0,  0, 255);
    table_row(OP_LOAD, 31, 31,   0,  0,  0, UNTYPED);
    table_row(OP_READ, 31, 31,   0,  0,  0, 0);
    table_row(OP_LOAD, 17,  9, int'(CELL_OPEN), 0, 0, UNTYPED);
    table_row(OP_READ, 17,  9,   0,  0,  0, int'(CELL_OPEN));
    table_row(OP_SOLVE, 5,  5,   0,  5,  5, 1);
    table_row(OP_READ,  5,  5,   0,  0,  0, int'(CELL_VISITED));
    table_row(OP_SOLVE, 10, 10,  0, 31, 31, 0);
    table_row(OP_READ, 10, 10,   0,  0,  0, int'(CELL_DEAD));
    table_row(OP_LOAD,  1,  0, int'(CELL_OPEN), 0, 0, UNTYPED);
    table_row(OP_LOAD,  0,  1, int'(CELL_OPEN), 0, 0, UNTYPED);
    table_row(OP_SOLVE, 0,  0,   0,  0,  1, UNTYPED);
    table_row(OP_READ,  1,  0,   0,  0,  0, UNTYPED);
    table_row(OP_READ,  0,  1,   0,  0,  0, UNTYPED);
    table_row(OP_LOAD, 30, 31, int'(CELL_OPEN), 0, 0, UNTYPED);
    table_row(OP_LOAD, 31, 30, int'(CELL_OPEN), 0, 0, UNTYPED);
    table_row(OP_SOLVE, 31, 31, 0,  0,  0, UNTYPED);
    table_row(OP_READ, 30, 31,   0,  0,  0, UNTYPED);
    table_row(OP_READ, 31, 30,   0,  0,  0, UNTYPED);
    table_row(OP_READ, 31, 31,   0,  0,  0, UNTYPED);
    table_row(OP_RSVD, 31, 31, 255, 31, 31, UNTYPED);
    table_row(OP_SOLVE, 0, 31,   0, 31,  0, UNTYPED);
    table_row(OP_READ,  0, 31,   0,  0,  0, UNTYPED);
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].typed);

    random_mazes();

    // Wait out every awaited result, then leave room for anything stray.
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
